// ----- src/esbd_pkg.sv -----
// Shared constants, register map and types for the silence boundary detector.
package esbd_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int WINDOW_MAX  = 16384;
   localparam int HIST_AW     = $clog2(WINDOW_MAX);
   localparam int LEN_W       = 15;
   localparam int THR_W       = 48;
   localparam int SUM_W       = 48;
   localparam int POS_W       = 32;
   localparam int DC_W        = 16;
   localparam int DIFF_W      = ((SAMPLE_BITS > DC_W) ? SAMPLE_BITS : DC_W) + 1;
   localparam int ENERGY_W    = 2 * DIFF_W;

   localparam int ADDR_W      = 5;
   localparam int DATA_W      = 64;
   localparam int REG_IDX_W   = 2;

   localparam logic [REG_IDX_W-1:0] REG_WINDOW_LENGTH    = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_ENERGY_THRESHOLD = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_MIN_INTERVAL     = 2'd2;
   localparam logic [REG_IDX_W-1:0] REG_DC_OFFSET        = 2'd3;

   localparam logic [LEN_W-1:0] WINDOW_LENGTH_RESET    = 15'd3200;
   localparam logic [THR_W-1:0] ENERGY_THRESHOLD_RESET = 48'd536870912;
   localparam logic [POS_W-1:0] MIN_INTERVAL_RESET     = 32'd16000;
   localparam logic [DC_W-1:0]  DC_OFFSET_RESET        = 16'd0;

   localparam int RQ_DEPTH = 8;
   localparam int RQ_AW    = $clog2(RQ_DEPTH);

   localparam int RES_KINDS = 3;
   localparam int RES_START = 0;
   localparam int RES_BOUND = 1;
   localparam int RES_END   = 2;

   typedef struct packed {
      logic             has_start;
      logic             has_bound;
      logic             has_end;
      logic [POS_W-1:0] bound_pos;
      logic [POS_W-1:0] total;
   } res_rec_type;

endpackage

// ----- src/esbd_ifs.sv -----
// Word channel interfaces for sample input and boundary output.
interface esbd_req_if
   import esbd_pkg::*;
();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;
   logic                          last_sample;

   modport source (output valid, sample, last_sample, input ready);
   modport sink (input valid, sample, last_sample, output ready);
endinterface

interface esbd_rsp_if
   import esbd_pkg::*;
();
   logic             valid;
   logic             ready;
   logic [POS_W-1:0] boundary_position;
   logic             is_end_of_audio;
   logic             last_of_run;

   modport source (output valid, boundary_position, is_end_of_audio, last_of_run, input ready);
   modport sink (input valid, boundary_position, is_end_of_audio, last_of_run, output ready);
endinterface

// ----- src/energy_silence_boundary_detector.sv -----
// Short-time energy silence boundary detector, top level.
//
//   channel | direction | word                                            | handshake
//   req     | in        | sample, last_sample                             | valid/ready
//   rsp     | out       | boundary_position, is_end_of_audio, last_of_run | valid/ready
//   csr     | in/out    | window_length, energy_threshold, min_interval,  | APB, 8-byte stride
//           |           | dc_offset                                       |
//
// One sample enters per cycle while req.ready is high; stages 1-3 then feed the queue.
// Each sample gives zero to three output words; while rsp.ready is high, rsp drains one
// word per cycle from an eight-record queue, so input slows only when samples average
// more than one word. req.ready falls when the queue and the three stages in flight could
// fill the queue. Reset is synchronous and clears registers, counters and queue; the
// history memory is not cleared and needs no sweep. Writing window_length starts a new stream.
module energy_silence_boundary_detector
   import esbd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   esbd_req_if.sink          req,
   esbd_rsp_if.source        rsp,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready
);

   localparam int SUMX_W = SUM_W + 1;
   localparam int CNT_W  = RQ_AW + 1;
   localparam logic [LEN_W-1:0] WIN_MAX_L = LEN_W'(WINDOW_MAX);

   // configuration
   logic [LEN_W-1:0]      window_length_ff;
   logic [THR_W-1:0]      energy_threshold_ff;
   logic [POS_W-1:0]      min_interval_ff;
   logic signed [DC_W-1:0] dc_offset_ff;
   logic                  cfg_wr;
   logic [REG_IDX_W-1:0]  cfg_idx;
   logic                  cfg_win_wr;
   logic [LEN_W-1:0]      eff_len;
   logic [LEN_W-1:0]      pos_off;

   // front end
   logic                  accept;
   logic [POS_W-1:0]      samples_seen_ff;
   logic [POS_W-1:0]      cnt_in;
   logic [HIST_AW-1:0]    write_idx_ff;
   logic [HIST_AW-1:0]    write_idx_in;
   logic signed [SAMPLE_BITS-1:0] hist_mem_ff [WINDOW_MAX];
   logic signed [SAMPLE_BITS-1:0] hist_rd_ff;

   // stage 1
   logic                  s1_valid_ff;
   logic signed [SAMPLE_BITS-1:0] s1_sample_ff;
   logic                  s1_first_ff;
   logic                  s1_sub_ff;
   logic [POS_W-1:0]      s1_cnt_ff;
   logic                  s1_last_ff;
   logic signed [DIFF_W-1:0]   d_new;
   logic signed [DIFF_W-1:0]   d_old;
   logic signed [ENERGY_W-1:0] p_new;
   logic signed [ENERGY_W-1:0] p_old;

   // stage 2
   logic                  s2_valid_ff;
   logic [ENERGY_W-1:0]   s2_e_new_ff;
   logic [ENERGY_W-1:0]   s2_e_old_ff;
   logic                  s2_first_ff;
   logic                  s2_sub_ff;
   logic                  s2_window_ff;
   logic [POS_W-1:0]      s2_pos_ff;
   logic [POS_W-1:0]      s2_cnt_ff;
   logic                  s2_last_ff;
   logic [SUM_W-1:0]      energy_sum_ff;
   logic [SUMX_W-1:0]     sum_diff;
   logic [SUM_W-1:0]      sum_base;
   logic [SUMX_W-1:0]     sum_add;
   logic [SUM_W-1:0]      sum_in;

   // stage 3
   logic                  s3_valid_ff;
   logic                  s3_first_ff;
   logic                  s3_window_ff;
   logic [POS_W-1:0]      s3_pos_ff;
   logic [POS_W-1:0]      s3_cnt_ff;
   logic                  s3_last_ff;
   logic [SUM_W-1:0]      s3_sum_ff;
   logic [POS_W-1:0]      last_boundary_ff;
   logic [POS_W:0]        bound_limit;
   logic                  bound_hit;
   logic                  push;
   res_rec_type           push_rec;

   // result queue
   res_rec_type           rq_mem_ff [RQ_DEPTH];
   logic [RQ_AW-1:0]      rq_wr_ff;
   logic [RQ_AW-1:0]      rq_rd_ff;
   logic [CNT_W-1:0]      rq_count_ff;
   logic [CNT_W-1:0]      rq_count_in;
   logic [CNT_W-1:0]      occupancy;
   logic                  pop;
   res_rec_type           head;
   logic [RES_KINDS-1:0]  done_ff;
   logic [RES_KINDS-1:0]  pending;
   logic [RES_KINDS-1:0]  cur_mask;
   logic                  rsp_fire;

   // ---------------- configuration port ----------------
   assign pready     = 1'b1;
   assign cfg_wr     = psel & penable & pwrite;
   assign cfg_idx    = paddr[ADDR_W-1:3];
   assign cfg_win_wr = cfg_wr && (cfg_idx == REG_WINDOW_LENGTH);

   always_ff @(posedge clock) begin
      if (reset) begin
         window_length_ff    <= WINDOW_LENGTH_RESET;
         energy_threshold_ff <= ENERGY_THRESHOLD_RESET;
         min_interval_ff     <= MIN_INTERVAL_RESET;
         dc_offset_ff        <= DC_OFFSET_RESET;
      end else if (cfg_wr) begin
         unique case (cfg_idx)
            REG_WINDOW_LENGTH:    window_length_ff    <= pwdata[LEN_W-1:0];
            REG_ENERGY_THRESHOLD: energy_threshold_ff <= pwdata[THR_W-1:0];
            REG_MIN_INTERVAL:     min_interval_ff     <= pwdata[POS_W-1:0];
            REG_DC_OFFSET:        dc_offset_ff        <= pwdata[DC_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (cfg_idx)
         REG_WINDOW_LENGTH:    prdata = DATA_W'(window_length_ff);
         REG_ENERGY_THRESHOLD: prdata = DATA_W'(energy_threshold_ff);
         REG_MIN_INTERVAL:     prdata = DATA_W'(min_interval_ff);
         REG_DC_OFFSET:        prdata = DATA_W'($unsigned(dc_offset_ff));
         default:              prdata = '0;
      endcase
   end

   always_comb begin
      priority if (window_length_ff == '0) begin
         eff_len = LEN_W'(1);
      end else if (32'(window_length_ff) > 32'(WINDOW_MAX)) begin
         eff_len = WIN_MAX_L;
      end else begin
         eff_len = window_length_ff;
      end
   end

   assign pos_off = eff_len - (eff_len >> 1) - LEN_W'(1);

   // ---------------- front end: counters and history ----------------
   assign occupancy = rq_count_ff + CNT_W'(s1_valid_ff) + CNT_W'(s2_valid_ff)
                    + CNT_W'(s3_valid_ff);
   assign req.ready = !reset && (occupancy < CNT_W'(RQ_DEPTH));
   assign accept    = req.valid && req.ready;

   assign cnt_in = (samples_seen_ff == '1) ? samples_seen_ff : samples_seen_ff + POS_W'(1);
   assign write_idx_in = ((LEN_W'(write_idx_ff) + LEN_W'(1)) == eff_len) ? '0
                       : write_idx_ff + HIST_AW'(1);

   always_ff @(posedge clock) begin
      if (reset || cfg_win_wr) begin
         samples_seen_ff <= '0;
         write_idx_ff    <= '0;
      end else if (accept) begin
         samples_seen_ff <= req.last_sample ? '0 : cnt_in;
         write_idx_ff    <= req.last_sample ? '0 : write_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         hist_rd_ff                <= hist_mem_ff[write_idx_ff];
         hist_mem_ff[write_idx_ff] <= req.sample;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_sample_ff <= req.sample;
         s1_first_ff  <= (samples_seen_ff == '0);
         s1_sub_ff    <= (samples_seen_ff >= POS_W'(eff_len));
         s1_cnt_ff    <= cnt_in;
         s1_last_ff   <= req.last_sample;
      end
   end

   // ---------------- stage 1: squares ----------------
   assign d_new = DIFF_W'(s1_sample_ff) - DIFF_W'(dc_offset_ff);
   assign d_old = DIFF_W'(hist_rd_ff) - DIFF_W'(dc_offset_ff);
   assign p_new = d_new * d_new;
   assign p_old = d_old * d_old;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         s2_e_new_ff  <= $unsigned(p_new);
         s2_e_old_ff  <= $unsigned(p_old);
         s2_first_ff  <= s1_first_ff;
         s2_sub_ff    <= s1_sub_ff;
         s2_window_ff <= (s1_cnt_ff >= POS_W'(eff_len));
         s2_pos_ff    <= s1_cnt_ff - POS_W'(pos_off);
         s2_cnt_ff    <= s1_cnt_ff;
         s2_last_ff   <= s1_last_ff;
      end
   end

   // ---------------- stage 2: window sum ----------------
   assign sum_diff = {1'b0, energy_sum_ff} - SUMX_W'(s2_e_old_ff);

   always_comb begin
      priority if (!s2_sub_ff) begin
         sum_base = energy_sum_ff;
      end else if (sum_diff[SUM_W]) begin
         sum_base = '0;
      end else begin
         sum_base = sum_diff[SUM_W-1:0];
      end
   end

   assign sum_add = {1'b0, sum_base} + SUMX_W'(s2_e_new_ff);
   assign sum_in  = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];

   always_ff @(posedge clock) begin
      if (reset || cfg_win_wr) begin
         energy_sum_ff <= '0;
      end else if (s2_valid_ff) begin
         energy_sum_ff <= s2_last_ff ? '0 : sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_valid_ff) begin
         s3_first_ff  <= s2_first_ff;
         s3_window_ff <= s2_window_ff;
         s3_pos_ff    <= s2_pos_ff;
         s3_cnt_ff    <= s2_cnt_ff;
         s3_last_ff   <= s2_last_ff;
         s3_sum_ff    <= sum_in;
      end
   end

   // ---------------- stage 3: boundary decision ----------------
   assign bound_limit = {1'b0, last_boundary_ff} + {1'b0, min_interval_ff};
   assign bound_hit   = s3_window_ff && (s3_sum_ff < energy_threshold_ff)
                     && ({1'b0, s3_pos_ff} > bound_limit);

   always_ff @(posedge clock) begin
      if (reset || cfg_win_wr) begin
         last_boundary_ff <= '0;
      end else if (s3_valid_ff) begin
         priority if (s3_last_ff) begin
            last_boundary_ff <= '0;
         end else if (bound_hit) begin
            last_boundary_ff <= s3_pos_ff;
         end
      end
   end

   assign push_rec.has_start = s3_first_ff;
   assign push_rec.has_bound = bound_hit;
   assign push_rec.has_end   = s3_last_ff;
   assign push_rec.bound_pos = s3_pos_ff;
   assign push_rec.total     = s3_cnt_ff;
   assign push = s3_valid_ff && (s3_first_ff || bound_hit || s3_last_ff);

   // ---------------- result queue and word output ----------------
   assign head    = rq_mem_ff[rq_rd_ff];
   assign pending = {head.has_end, head.has_bound, head.has_start} & ~done_ff;

   always_comb begin
      cur_mask = '0;
      priority if (pending[RES_START]) begin
         cur_mask[RES_START]   = 1'b1;
         rsp.boundary_position = '0;
         rsp.is_end_of_audio   = 1'b0;
      end else if (pending[RES_BOUND]) begin
         cur_mask[RES_BOUND]   = 1'b1;
         rsp.boundary_position = head.bound_pos;
         rsp.is_end_of_audio   = 1'b0;
      end else begin
         cur_mask[RES_END]     = 1'b1;
         rsp.boundary_position = head.total;
         rsp.is_end_of_audio   = 1'b1;
      end
   end

   assign rsp.valid       = (rq_count_ff != '0);
   assign rsp.last_of_run = ((pending & (pending - RES_KINDS'(1))) == '0);
   assign rsp_fire        = rsp.valid && rsp.ready;
   assign pop             = rsp_fire && rsp.last_of_run;

   always_comb begin
      unique case ({push, pop})
         2'b10:   rq_count_in = rq_count_ff + CNT_W'(1);
         2'b01:   rq_count_in = rq_count_ff - CNT_W'(1);
         default: rq_count_in = rq_count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rq_wr_ff    <= '0;
         rq_rd_ff    <= '0;
         rq_count_ff <= '0;
         done_ff     <= '0;
      end else begin
         rq_count_ff <= rq_count_in;
         if (push) begin
            rq_wr_ff <= rq_wr_ff + RQ_AW'(1);
         end
         if (pop) begin
            rq_rd_ff <= rq_rd_ff + RQ_AW'(1);
            done_ff  <= '0;
         end else if (rsp_fire) begin
            done_ff  <= done_ff | cur_mask;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         rq_mem_ff[rq_wr_ff] <= push_rec;
      end
   end

endmodule

// ----- src/esbd_checker.sv -----
// Port-level assertions for the silence boundary detector, bound to the top level.
module esbd_checker
   import esbd_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [POS_W-1:0] rsp_boundary_position,
   input logic             rsp_is_end_of_audio,
   input logic             rsp_last_of_run
);

   a_no_accept_in_reset: assert property (@(posedge clock) reset |-> !req_ready)
      else $error("req ready during reset");

   a_rsp_idle_after_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_boundary_position)
         && $stable(rsp_is_end_of_audio) && $stable(rsp_last_of_run))
      else $error("stalled rsp word changed");

   a_end_closes_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_end_of_audio |-> rsp_last_of_run)
      else $error("end-of-audio word not last of run");

   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_of_run |=> rsp_valid)
      else $error("run broken before its last word");

endmodule

bind energy_silence_boundary_detector esbd_checker u_esbd_checker (
   .clock                 (clock),
   .reset                 (reset),
   .req_ready             (req.ready),
   .rsp_valid             (rsp.valid),
   .rsp_ready             (rsp.ready),
   .rsp_boundary_position (rsp.boundary_position),
   .rsp_is_end_of_audio   (rsp.is_end_of_audio),
   .rsp_last_of_run       (rsp.last_of_run)
);
